// ===== src/rcpwc_pkg.sv =====
// Shared types, constants and helpers for the RC pulse width capture block.
// No dependencies; every other file in src depends on this package.
`default_nettype none

package rcpwc_pkg;

    localparam int CNT_W     = 32;  // tick counter and width
    localparam int DUTY_W    = 16;  // Q0.16 duty
    localparam int NUM_CH    = 4;   // receiver pins
    localparam int CH_W      = 2;   // channel number
    localparam int FN_W      = 2;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TWO  = 2'd2;

    localparam logic [DUTY_W-1:0] THR_CEIL_RESET = 16'd52429;

    typedef enum logic [FN_W-1:0] {
        FN_THROTTLE,
        FN_ROLL,
        FN_PITCH,
        FN_YAW
    } t_stick_fn;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STICK_MODE,
        REG_MIN_WIDTH,
        REG_MAX_WIDTH,
        REG_THR_CEIL,
        REG_OFFSET_ONE,
        REG_OFFSET_TWO,
        REG_OFFSET_THREE,
        REG_OFFSET_FOUR
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_WIDTH,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic ge_max;
        logic le_min;
    } t_width_flags;

    // One bit of x - y - b: returns {borrow out, difference}.
    function automatic logic [1:0] sub_bit(input logic x, input logic y, input logic b);
        logic d;
        logic bo;
        d  = x ^ y ^ b;
        bo = (~x & y) | (~(x ^ y) & b);
        return {bo, d};
    endfunction

    function automatic t_stick_fn stick_fn(input logic [MODE_W-1:0] mode,
                                           input logic [CH_W-1:0] ch);
        t_stick_fn fn;
        if (mode == MODE_TWO) begin
            case (ch)
                2'd0:    fn = FN_PITCH;
                2'd1:    fn = FN_ROLL;
                2'd2:    fn = FN_THROTTLE;
                default: fn = FN_YAW;
            endcase
        end else begin
            case (ch)
                2'd0:    fn = FN_THROTTLE;
                2'd1:    fn = FN_YAW;
                2'd2:    fn = FN_PITCH;
                default: fn = FN_ROLL;
            endcase
        end
        return fn;
    endfunction

endpackage

`default_nettype wire

// ===== src/rcpwc_ifs.sv =====
// Handshake channels of the pulse width capture block: sample in, result out, config.
// Depends on rcpwc_pkg for field widths.
`default_nettype none

interface rcpwc_in_if;
    logic                           valid;
    logic                           ready;
    logic [rcpwc_pkg::NUM_CH-1:0]   pin_levels;
    logic [rcpwc_pkg::CNT_W-1:0]    timestamp;

    modport source (output valid, pin_levels, timestamp, input ready);
    modport sink   (input valid, pin_levels, timestamp, output ready);
endinterface

interface rcpwc_out_if;
    logic                           valid;
    logic                           ready;
    logic [rcpwc_pkg::FN_W-1:0]     stick_function;
    logic [rcpwc_pkg::CNT_W-1:0]    raw_width;
    logic [rcpwc_pkg::DUTY_W-1:0]   duty;
    logic                           last_of_run;

    modport source (output valid, stick_function, raw_width, duty, last_of_run, input ready);
    modport sink   (input valid, stick_function, raw_width, duty, last_of_run, output ready);
endinterface

interface rcpwc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rcpwc_pkg::CFG_IDX_W-1:0]  index;
    logic [rcpwc_pkg::CNT_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/rcpwc_width_unit.sv =====
// Bit-serial width unit: width = now - edge - offset, plus width - min, max - min
// and the min/max compares, one bit per cycle LSB first. Depends on rcpwc_pkg.
`default_nettype none

module rcpwc_width_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rcpwc_pkg::CNT_W-1:0]   i_now,
    input  logic [rcpwc_pkg::CNT_W-1:0]   i_edge,
    input  logic [rcpwc_pkg::CNT_W-1:0]   i_offset,
    input  logic [rcpwc_pkg::CNT_W-1:0]   i_min,
    input  logic [rcpwc_pkg::CNT_W-1:0]   i_max,
    output logic [rcpwc_pkg::CNT_W-1:0]   o_width,
    output logic [rcpwc_pkg::CNT_W-1:0]   o_num,
    output logic [rcpwc_pkg::CNT_W-1:0]   o_den,
    output rcpwc_pkg::t_width_flags       o_flags,
    output logic                          o_busy,
    output logic                          o_done
);
    import rcpwc_pkg::*;

    localparam int CNT_BITS = $clog2(CNT_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_W-1:0]    r_now, r_edge, r_off, r_min, r_max;
    logic [CNT_W-1:0]    r_w, r_a, r_d;
    logic                r_b1, r_b2, r_b3, r_b4, r_b5;
    logic                r_anz;
    t_width_flags        r_flags;

    logic [1:0] s1, s2, s3, s4, s5;
    logic       last_bit;

    always_comb begin
        s1 = sub_bit(r_now[0], r_edge[0], r_b1);
        s2 = sub_bit(s1[0], r_off[0], r_b2);     // width bit
        s3 = sub_bit(s2[0], r_min[0], r_b3);     // width - min
        s4 = sub_bit(r_max[0], r_min[0], r_b4);  // max - min
        s5 = sub_bit(s2[0], r_max[0], r_b5);     // width - max, borrow only
        last_bit = (r_cnt == CNT_BITS'(CNT_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_bit) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_now  <= i_now;
            r_edge <= i_edge;
            r_off  <= i_offset;
            r_min  <= i_min;
            r_max  <= i_max;
            r_b1   <= 1'b0;
            r_b2   <= 1'b0;
            r_b3   <= 1'b0;
            r_b4   <= 1'b0;
            r_b5   <= 1'b0;
            r_anz  <= 1'b0;
        end else if (r_busy) begin
            // advance every operand by one bit
            r_now  <= {1'b0, r_now[CNT_W-1:1]};
            r_edge <= {1'b0, r_edge[CNT_W-1:1]};
            r_off  <= {1'b0, r_off[CNT_W-1:1]};
            r_min  <= {1'b0, r_min[CNT_W-1:1]};
            r_max  <= {1'b0, r_max[CNT_W-1:1]};
            r_w    <= {s2[0], r_w[CNT_W-1:1]};
            r_a    <= {s3[0], r_a[CNT_W-1:1]};
            r_d    <= {s4[0], r_d[CNT_W-1:1]};
            r_b1   <= s1[1];
            r_b2   <= s2[1];
            r_b3   <= s3[1];
            r_b4   <= s4[1];
            r_b5   <= s5[1];
            r_anz  <= r_anz | s3[0];
            if (last_bit) begin
                r_flags.ge_max <= ~s5[1];
                // below min or exactly min
                r_flags.le_min <= s3[1] | ~(r_anz | s3[0]);
            end
        end
    end

    assign o_width = r_w;
    assign o_num   = r_a;
    assign o_den   = r_d;
    assign o_flags = r_flags;
    assign o_busy  = r_busy;
    assign o_done  = r_done;

endmodule

`default_nettype wire

// ===== src/rcpwc_scale_div.sv =====
// Digit-serial scale and divide: quot = floor(ceil * num / den), num < den,
// taking one ceiling bit per add and reduce step, MSB first. Depends on rcpwc_pkg.
`default_nettype none

module rcpwc_scale_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rcpwc_pkg::DUTY_W-1:0]  i_ceil,
    input  logic [rcpwc_pkg::CNT_W-1:0]   i_num,
    input  logic [rcpwc_pkg::CNT_W-1:0]   i_den,
    output logic [rcpwc_pkg::DUTY_W-1:0]  o_quot,
    output logic                          o_done
);
    import rcpwc_pkg::*;

    localparam int STEP_BITS = $clog2(DUTY_W);
    localparam int REM_W     = CNT_W + 2;

    logic                 r_busy;
    logic                 r_phase;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_cnt;
    logic [DUTY_W-1:0]    r_ceil;
    logic [CNT_W-1:0]     r_num;
    logic [CNT_W-1:0]     r_den;
    logic [REM_W-1:0]     r_rem;
    logic [DUTY_W-1:0]    r_quot;

    logic [REM_W-1:0] add_rem;
    logic [REM_W-1:0] den1;
    logic [REM_W-1:0] den2;
    logic             last_step;

    always_comb begin
        den1      = {2'b00, r_den};
        den2      = {1'b0, r_den, 1'b0};
        add_rem   = {r_rem[REM_W-2:0], 1'b0}
                  + (r_ceil[DUTY_W-1] ? {2'b00, r_num} : {REM_W{1'b0}});
        last_step = (r_cnt == STEP_BITS'(DUTY_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= '0;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (last_step) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Remainder stays below den after each step; after the add it is below 3*den.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ceil <= i_ceil;
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_rem  <= add_rem;
                r_quot <= {r_quot[DUTY_W-2:0], 1'b0};
                r_ceil <= {r_ceil[DUTY_W-2:0], 1'b0};
            end else if (r_rem >= den2) begin
                r_rem  <= r_rem - den2;
                r_quot <= r_quot + DUTY_W'(2);
            end else if (r_rem >= den1) begin
                r_rem  <= r_rem - den1;
                r_quot <= r_quot + DUTY_W'(1);
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== src/rc_pulse_width_capture.sv =====
// Top level of the four-channel RC pulse width capture block: config registers,
// edge tracking, channel sequencer and output register. Depends on rcpwc_pkg,
// rcpwc_ifs, rcpwc_width_unit and rcpwc_scale_div.
//
//   channel  | dir | beat contents
//   ---------+-----+-----------------------------------------------------
//   i_in     | in  | pin_levels[3:0], timestamp[31:0]
//   o_out    | out | stick_function[1:0], raw_width[31:0], duty[15:0], last_of_run
//   i_cfg    | in  | index[2:0], data[31:0]; always ready
//
// A sample is accepted in idle and updates all edge state at once. In stick modes, each
// falling edge passes scan, load, the bit-serial width unit (one bit per cycle over 32
// bits, then done) and emit, plus the scale/divide unit (one ceiling bit per add and
// reduce step, then done) when the width lies strictly between min and max. The output
// register holds a result until taken; a stalled output holds the sequencer in its emit
// state. Synchronous reset clears control, config and edge state; no clearing pass.
`default_nettype none

module rc_pulse_width_capture (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rcpwc_in_if.sink     i_in,
    rcpwc_out_if.source  o_out,
    rcpwc_cfg_if.sink    i_cfg
);
    import rcpwc_pkg::*;

    // configuration
    logic [MODE_W-1:0] r_mode;
    logic [CNT_W-1:0]  r_min;
    logic [CNT_W-1:0]  r_max;
    logic [DUTY_W-1:0] r_thr;
    logic [CNT_W-1:0]  r_offset [NUM_CH];

    // edge tracking
    logic [CNT_W-1:0]  r_edge_time [NUM_CH];
    logic [NUM_CH-1:0] r_high;
    logic [CNT_W-1:0]  r_now;
    logic [NUM_CH-1:0] r_fall;
    logic [CH_W-1:0]   r_ch;
    logic              r_last;

    t_state r_state, n_state;

    // output register
    logic              r_out_valid;
    t_stick_fn         r_out_fn;
    logic [CNT_W-1:0]  r_out_width;
    logic [DUTY_W-1:0] r_out_duty;
    logic              r_out_last;

    logic              in_ready;
    logic              in_take;
    logic              w_start;
    logic              d_start;
    logic              emit_load;
    logic [CH_W-1:0]   scan_ch;
    logic [NUM_CH-1:0] fall_clr;
    logic              emit_mode;

    logic [CNT_W-1:0]  w_width;
    logic [CNT_W-1:0]  w_num;
    logic [CNT_W-1:0]  w_den;
    t_width_flags      w_flags;
    logic              w_busy;
    logic              w_done;
    logic [DUTY_W-1:0] d_quot;
    logic              d_done;

    t_stick_fn         cur_fn;
    logic [DUTY_W-1:0] cur_ceil;
    logic [DUTY_W-1:0] cur_duty;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign in_take     = i_in.valid & in_ready;
    assign emit_mode   = (r_mode == MODE_ONE) || (r_mode == MODE_TWO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
            r_min  <= '0;
            r_max  <= '0;
            r_thr  <= THR_CEIL_RESET;
            for (int i = 0; i < NUM_CH; i++) begin
                r_offset[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_STICK_MODE:   r_mode      <= i_cfg.data[MODE_W-1:0];
                REG_MIN_WIDTH:    r_min       <= i_cfg.data;
                REG_MAX_WIDTH:    r_max       <= i_cfg.data;
                REG_THR_CEIL:     r_thr       <= i_cfg.data[DUTY_W-1:0];
                REG_OFFSET_ONE:   r_offset[0] <= i_cfg.data;
                REG_OFFSET_TWO:   r_offset[1] <= i_cfg.data;
                REG_OFFSET_THREE: r_offset[2] <= i_cfg.data;
                REG_OFFSET_FOUR:  r_offset[3] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // lowest pending falling edge goes first
    always_comb begin
        scan_ch = '0;
        for (int i = NUM_CH - 1; i >= 0; i--) begin
            if (r_fall[i]) begin
                scan_ch = CH_W'(i);
            end
        end
        fall_clr = r_fall & (r_fall - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        in_ready  = 1'b0;
        w_start   = 1'b0;
        d_start   = 1'b0;
        emit_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_state = (r_fall == '0) ? ST_IDLE : ST_LOAD;
            end
            ST_LOAD: begin
                w_start = 1'b1;
                n_state = ST_WIDTH;
            end
            ST_WIDTH: begin
                if (w_done) begin
                    if (!w_flags.ge_max && !w_flags.le_min) begin
                        d_start = 1'b1;
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_DIV: begin
                if (d_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    emit_load = 1'b1;
                    n_state   = ST_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high <= '0;
            r_fall <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_edge_time[i] <= '0;
            end
        end else if (in_take) begin
            r_high <= i_in.pin_levels;
            r_fall <= emit_mode ? (r_high & ~i_in.pin_levels) : '0;
            for (int i = 0; i < NUM_CH; i++) begin
                if (!r_high[i] && i_in.pin_levels[i]) begin
                    r_edge_time[i] <= i_in.timestamp;
                end
            end
        end else if (r_state == ST_SCAN) begin
            r_fall <= fall_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now <= i_in.timestamp;
        end
        if (r_state == ST_SCAN) begin
            r_ch   <= scan_ch;
            r_last <= (fall_clr == '0);
        end
    end

    rcpwc_width_unit u_width (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_now    (r_now),
        .i_edge   (r_edge_time[r_ch]),
        .i_offset (r_offset[r_ch]),
        .i_min    (r_min),
        .i_max    (r_max),
        .o_width  (w_width),
        .o_num    (w_num),
        .o_den    (w_den),
        .o_flags  (w_flags),
        .o_busy   (w_busy),
        .o_done   (w_done)
    );

    always_comb begin
        cur_fn   = stick_fn(r_mode, r_ch);
        cur_ceil = (cur_fn == FN_THROTTLE) ? r_thr : {DUTY_W{1'b1}};
        if (w_flags.ge_max) begin
            cur_duty = cur_ceil;
        end else if (w_flags.le_min) begin
            cur_duty = '0;
        end else begin
            cur_duty = d_quot;
        end
    end

    rcpwc_scale_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_ceil  (cur_ceil),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quot  (d_quot),
        .o_done  (d_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_fn    <= cur_fn;
            r_out_width <= w_width;
            r_out_duty  <= cur_duty;
            r_out_last  <= r_last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.stick_function = r_out_fn;
    assign o_out.raw_width      = r_out_width;
    assign o_out.duty           = r_out_duty;
    assign o_out.last_of_run    = r_out_last;

`ifndef SYNTH
    a_scan_drops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_fall != '0)
        |=> ($countones(r_fall) + 1 == $countones($past(r_fall))))
        else $error("scan did not drop exactly one pending channel");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_fall == '0))
        else $error("idle with falling edges still pending");

    a_last_means_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && r_last) |-> (r_fall == '0))
        else $error("last_of_run set while channels remain");

    a_div_after_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !w_busy)
        else $error("width unit busy during division");
`endif

endmodule

`default_nettype wire
